[hdl/swms_pkg.sv]
// ----------------------------------------------------------------------------
// swms_pkg
// Shared types and constants for the square wave melody sequencer: note
// table geometry, beat layouts, item kinds and register indexes.
// ----------------------------------------------------------------------------
package swms_pkg;

    // note table geometry and counter width
    localparam int TABLE_DEPTH = 256;
    localparam int COUNT_WIDTH = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // entry pointer can run one past the last entry
    localparam int ENTRY_W     = ADDR_W + 1;

    // fixed field widths of the stream beats
    localparam int IDX_W     = 8;
    localparam int FIELD_W   = 16;
    localparam int LEVEL_W   = 8;
    localparam int KIND_W    = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // item kinds carried in tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 2'd0,
        KIND_WRITE     = 2'd1,
        KIND_START     = 2'd2,
        KIND_KEY_START = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_LEVEL = 1'b0,
        REG_KEY_ENABLE = 1'b1
    } cfg_reg_t;

    // input beat, lowest field in the lowest bits
    typedef struct packed {
        logic [FIELD_W-1:0] note_toggles;
        logic [FIELD_W-1:0] note_period;
        logic [IDX_W-1:0]   entry_index;
    } in_beat_t;

    // result beat, lowest field in the lowest bits
    typedef struct packed {
        logic [M_DATA_W-LEVEL_W-3:0] pad;
        logic                        playing;
        logic [LEVEL_W-1:0]          dac_level;
        logic                        pin_level;
    } out_beat_t;

    // one note table entry
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] period;
        logic [COUNT_WIDTH-1:0] toggles;
    } entry_t;

    // note table access from the sequencer core
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        entry_t            wdata;
    } mem_req_t;

endpackage

[hdl/swms_table.sv]
// ----------------------------------------------------------------------------
// swms_table
// Note table: single port synchronous memory, one write or one read per
// cycle, read data registered.
// ----------------------------------------------------------------------------
module swms_table (
    input  logic              aclk,
    input  swms_pkg::mem_req_t req,
    output swms_pkg::entry_t   rd_entry
);
    import swms_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_entry_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rd_entry_reg <= mem[req.addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

[hdl/swms_core.sv]
// ----------------------------------------------------------------------------
// swms_core
// Sequencer core: issues note table accesses as beats are taken, then
// applies each item to the wave state with the table data as it leaves the
// second stage, and registers the resulting levels as the output beat.
// ----------------------------------------------------------------------------
module swms_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // {note_toggles, note_period, entry_index} from bit 0 up: entry_index,
    // note_period, note_toggles
    input  logic [swms_pkg::S_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [swms_pkg::KIND_W-1:0]    s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // from bit 0 up: pin_level, dac_level, playing, zero fill
    output logic [swms_pkg::M_DATA_W-1:0]  m_tdata,
    // configuration
    input  logic [swms_pkg::LEVEL_W-1:0]   high_level,
    input  logic                           key_enable,
    // note table
    output swms_pkg::mem_req_t             mem_req,
    input  swms_pkg::entry_t               rd_entry
);
    import swms_pkg::*;

    in_beat_t in_beat;
    kind_t    in_kind;
    logic     in_fire;
    logic     out_free;
    logic     s2_fire;
    logic     in_idx_ok;

    // item waiting for its table data
    logic             s2_valid_reg;
    kind_t            s2_kind_reg;
    logic [IDX_W-1:0] s2_idx_reg;

    // wave state
    logic [COUNT_WIDTH-1:0] tick_count_reg,   tick_count_next;
    logic [COUNT_WIDTH-1:0] period_reg,       period_next;
    logic [COUNT_WIDTH-1:0] toggles_left_reg, toggles_left_next;
    logic [ENTRY_W-1:0]     next_entry_reg,   next_entry_next;
    logic                   phase_reg,        phase_next;
    logic [LEVEL_W-1:0]     dac_reg,          dac_next;
    logic                   active_reg,       active_next;

    // output beat
    logic      out_valid_reg;
    out_beat_t out_beat_reg;

    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   s2_idx_ok;
    logic                   next_ok;
    logic                   do_begin;

    assign in_beat  = in_beat_t'(s_tdata);
    assign in_kind  = kind_t'(s_tuser);
    assign out_free = !out_valid_reg || m_tready;
    assign s2_fire  = s2_valid_reg && out_free;
    assign s_tready = !s2_valid_reg || out_free;
    assign in_fire  = s_tvalid && s_tready;

    assign in_idx_ok = 32'(in_beat.entry_index) < 32'(TABLE_DEPTH);
    assign s2_idx_ok = 32'(s2_idx_reg) < 32'(TABLE_DEPTH);
    assign next_ok   = next_entry_reg < ENTRY_W'(TABLE_DEPTH);
    assign tick_inc  = tick_count_reg + COUNT_WIDTH'(1);
    assign do_begin  = s2_idx_ok && ((s2_kind_reg == KIND_START) || key_enable);

    // wave state update for the item in the second stage
    always_comb begin
        tick_count_next   = tick_count_reg;
        period_next       = period_reg;
        toggles_left_next = toggles_left_reg;
        next_entry_next   = next_entry_reg;
        phase_next        = phase_reg;
        dac_next          = dac_reg;
        active_next       = active_reg;
        if (s2_fire) begin
            unique case (s2_kind_reg) inside
                KIND_TICK: begin
                    if (active_reg) begin
                        if (tick_inc >= period_reg) begin
                            tick_count_next = '0;
                            if (toggles_left_reg != '0) begin
                                toggles_left_next = toggles_left_reg - COUNT_WIDTH'(1);
                                phase_next        = !phase_reg;
                                dac_next          = phase_reg ? '0 : high_level;
                            end else if (next_ok && (rd_entry.period != '0)) begin
                                phase_next        = !phase_reg;
                                dac_next          = phase_reg ? '0 : high_level;
                                period_next       = rd_entry.period;
                                toggles_left_next = rd_entry.toggles;
                                next_entry_next   = next_entry_reg + ENTRY_W'(1);
                            end else begin
                                // end mark or off the table: stop low
                                dac_next          = '0;
                                phase_next        = 1'b0;
                                toggles_left_next = '0;
                                next_entry_next   = '0;
                                active_next       = 1'b0;
                            end
                        end else begin
                            tick_count_next = tick_inc;
                        end
                    end
                end
                KIND_WRITE: begin
                end
                KIND_START, KIND_KEY_START: begin
                    if (do_begin) begin
                        next_entry_next = ENTRY_W'(s2_idx_reg);
                        if (rd_entry.period != '0) begin
                            period_next       = rd_entry.period;
                            toggles_left_next = rd_entry.toggles;
                            next_entry_next   = ENTRY_W'(s2_idx_reg) + ENTRY_W'(1);
                            tick_count_next   = '0;
                            active_next       = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // table access: writes and start lookups at the beat index, ticks
    // look up the entry the previous item leaves as next
    always_comb begin
        mem_req.we            = in_fire && (in_kind == KIND_WRITE) && in_idx_ok;
        mem_req.re            = in_fire && (in_kind != KIND_WRITE);
        mem_req.wdata.period  = COUNT_WIDTH'(in_beat.note_period);
        mem_req.wdata.toggles = COUNT_WIDTH'(in_beat.note_toggles);
        if (in_kind == KIND_TICK) begin
            mem_req.addr = next_entry_next[ADDR_W-1:0];
        end else begin
            mem_req.addr = ADDR_W'(in_beat.entry_index);
        end
    end

    // second stage item registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s2_valid_reg <= s_tvalid;
        end
        if (in_fire) begin
            s2_kind_reg <= in_kind;
            s2_idx_reg  <= in_beat.entry_index;
        end
    end

    // wave state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg   <= '0;
            period_reg       <= '0;
            toggles_left_reg <= '0;
            next_entry_reg   <= '0;
            phase_reg        <= 1'b1;
            dac_reg          <= '0;
            active_reg       <= 1'b0;
        end else begin
            tick_count_reg   <= tick_count_next;
            period_reg       <= period_next;
            toggles_left_reg <= toggles_left_next;
            next_entry_reg   <= next_entry_next;
            phase_reg        <= phase_next;
            dac_reg          <= dac_next;
            active_reg       <= active_next;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s2_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (s2_fire) begin
            out_beat_reg.pad       <= '0;
            out_beat_reg.playing   <= active_next;
            out_beat_reg.dac_level <= dac_next;
            out_beat_reg.pin_level <= phase_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_beat_reg);

`ifndef ASSERT_OFF
    // dac only drives a level while the wave is high
    a_dac_follows_phase: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (dac_reg != '0) |-> phase_reg
    ) else $error("dac level nonzero while wave is low");

    // the tick counter rests at zero while idle
    a_idle_tick_clear: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (tick_count_reg == '0)
    ) else $error("tick counter moved while idle");

    // wave state moves only when an item leaves the second stage
    a_state_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s2_fire |=> ($stable(tick_count_reg) && $stable(next_entry_reg)
                      && $stable(active_reg) && $stable(phase_reg))
    ) else $error("wave state changed without an item");
`endif

endmodule

[hdl/square_wave_melody_sequencer_top.sv]
// ----------------------------------------------------------------------------
// square_wave_melody_sequencer_top
// Square wave melody sequencer: note table memory, sequencer core and
// configuration registers.
// ----------------------------------------------------------------------------
// path: a beat is held in the second stage, then registered as the result
// throughput: one beat per cycle unless m_tready stalls; the note table
//   access of each item uses the single port, issued as the beat is taken
// reset: aresetn synchronous active low; clears control and wave state but
//   wave phase, set to 1; high_level, key_enable to 1; table not cleared
module square_wave_melody_sequencer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // from bit 0 up: entry_index, note_period, note_toggles
    input  logic [swms_pkg::S_DATA_W-1:0]    s_tdata,
    // kind
    input  logic [swms_pkg::KIND_W-1:0]      s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // from bit 0 up: pin_level, dac_level, playing, zero fill
    output logic [swms_pkg::M_DATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [swms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import swms_pkg::*;

    logic [LEVEL_W-1:0] high_level_reg;
    logic               key_enable_reg;
    mem_req_t           mem_req;
    entry_t             rd_entry;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_level_reg <= LEVEL_W'(1);
            key_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HIGH_LEVEL: high_level_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_KEY_ENABLE: key_enable_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // note table
    swms_table u_table (
        .aclk     (aclk),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    // sequencer core
    swms_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .high_level (high_level_reg),
        .key_enable (key_enable_reg),
        .mem_req    (mem_req),
        .rd_entry   (rd_entry)
    );

endmodule
